@@ rtl/mst_pkg.sv @@
// Shared types and constants for the multi-slot one-shot timer block.
package mst_pkg;

  // Slot set and field widths
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int FUNC_W    = 2;

  // Command queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the command channel
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

  // Classified command kinds held in the queue
  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  duration;
    logic [TIME_W-1:0]  now;
  } queue_entry_t;

endpackage

@@ rtl/mst_in_if.sv @@
// Command channel: valid/ready handshake with timer command payload.
interface mst_in_if;
  import mst_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot_id;
  logic [TIME_W-1:0] duration;
  logic [TIME_W-1:0] now;

  modport source (output valid, func, slot_id, duration, now, input ready);
  modport sink   (input valid, func, slot_id, duration, now, output ready);
endinterface

@@ rtl/mst_out_if.sv @@
// Expiry channel: valid/ready handshake carrying expired slot indices.
interface mst_out_if;
  import mst_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] expired_slot;
  logic              last;

  modport source (output valid, expired_slot, last, input ready);
  modport sink   (input valid, expired_slot, last, output ready);
endinterface

@@ rtl/mst_front.sv @@
// Front end: accepts commands, drops no-op ones, and queues the rest.
module mst_front (
  input  logic                  clk,
  input  logic                  rst,
  mst_in_if.sink                cmd,
  output logic                  q_valid,
  output mst_pkg::queue_entry_t q_head,
  input  logic                  q_pop
);
  import mst_pkg::*;

  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(NUM_SLOTS);

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  queue_entry_t new_entry;
  logic         keep;
  logic         slot_ok;
  logic         push;

  // Classify: unused selector and out-of-range slots are dropped here
  assign slot_ok = ({1'b0, cmd.slot_id} < SLOT_LIMIT);

  always_comb begin
    keep               = 1'b0;
    new_entry.kind     = KIND_CHECK;
    new_entry.slot     = cmd.slot_id;
    new_entry.duration = cmd.duration;
    new_entry.now      = cmd.now;
    case (cmd.func)
      FUNC_START: begin
        new_entry.kind = KIND_START;
        keep           = slot_ok;
      end
      FUNC_CANCEL: begin
        new_entry.kind = KIND_CANCEL;
        keep           = slot_ok;
      end
      FUNC_CHECK: begin
        new_entry.kind = KIND_CHECK;
        keep           = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign cmd.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push      = cmd.valid && cmd.ready && keep;
  assign q_valid   = (count != '0);
  assign q_head    = entries[rd_ptr];

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (q_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= new_entry;
  end

endmodule

@@ rtl/mst_back.sv @@
// Back end: executes queued commands and scans slots for expiry on a check.
module mst_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  mst_pkg::queue_entry_t q_head,
  output logic                  q_pop,
  mst_out_if.source             expiry
);
  import mst_pkg::*;

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(NUM_SLOTS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] scan_idx_next;

  logic              armed [NUM_SLOTS];
  logic [TIME_W-1:0] start_time  [NUM_SLOTS];
  logic [TIME_W-1:0] expiry_span [NUM_SLOTS];

  // Hit held back until we know whether another one follows
  logic              pend_valid;
  logic              pend_valid_next;
  logic [SLOT_W-1:0] pend_slot;
  logic [SLOT_W-1:0] pend_slot_next;

  logic              out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic              out_last;

  logic              out_free;
  logic [TIME_W-1:0] elapsed;
  logic              hit;
  logic              load_out;
  logic              load_last;
  logic              arm_set;
  logic              arm_clr;
  logic [SLOT_W-1:0] arm_idx;

  assign out_free = !out_valid || expiry.ready;
  assign elapsed  = q_head.now - start_time[scan_idx];
  assign hit      = armed[scan_idx] && (elapsed >= expiry_span[scan_idx]);

  // Command execution and scan control
  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    q_pop           = 1'b0;
    load_out        = 1'b0;
    load_last       = 1'b0;
    arm_set         = 1'b0;
    arm_clr         = 1'b0;
    arm_idx         = q_head.slot;
    case (state)
      ST_EXEC: begin
        if (q_valid) begin
          case (q_head.kind)
            KIND_START: begin
              arm_set = 1'b1;
              q_pop   = 1'b1;
            end
            KIND_CANCEL: begin
              arm_clr = 1'b1;
              q_pop   = 1'b1;
            end
            KIND_CHECK: begin
              scan_idx_next = '0;
              state_next    = ST_SCAN;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // Stall only when a second hit must push the pending one out
        if (!(hit && pend_valid) || out_free) begin
          if (hit) begin
            arm_clr         = 1'b1;
            arm_idx         = scan_idx;
            load_out        = pend_valid;
            pend_valid_next = 1'b1;
            pend_slot_next  = scan_idx;
          end
          if (scan_idx == SCAN_LAST) begin
            state_next = ST_FLUSH;
          end else begin
            scan_idx_next = scan_idx + SLOT_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          q_pop      = q_valid;
          state_next = ST_EXEC;
        end else if (out_free) begin
          load_out        = 1'b1;
          load_last       = 1'b1;
          pend_valid_next = 1'b0;
          q_pop           = q_valid;
          state_next      = ST_EXEC;
        end
      end
      default: state_next = ST_EXEC;
    endcase
  end

  // Control registers and armed flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_EXEC;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) armed[i] <= 1'b0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      pend_valid <= pend_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (expiry.ready) begin
        out_valid <= 1'b0;
      end
      if (arm_set) armed[arm_idx] <= 1'b1;
      if (arm_clr) armed[arm_idx] <= 1'b0;
    end
  end

  // Payload registers: timer values, pending hit, output data
  always_ff @(posedge clk) begin
    if (arm_set) begin
      start_time[arm_idx]  <= q_head.now;
      expiry_span[arm_idx] <= q_head.duration;
    end
    pend_slot <= pend_slot_next;
    if (load_out) begin
      out_slot <= pend_slot;
      out_last <= load_last;
    end
  end

  assign expiry.valid        = out_valid;
  assign expiry.expired_slot = out_slot;
  assign expiry.last         = out_last;

endmodule

@@ rtl/multi_slot_oneshot_timers.sv @@
// Top level of the multi-slot one-shot timer block.
//
// Usage:
//   cmd carries one command per transaction: func selects start, cancel or
//   check; slot_id, duration and now qualify it. Unused selector values and
//   slot indices beyond the slot count are accepted and dropped.
//   expiry returns one transaction per expired slot of a check, in ascending
//   slot order; last is set on the final one of that check.
//   A two-entry command queue sits between the front end and the executing
//   back end, so commands keep being accepted while a check is in progress.
//   Start and cancel are executed straight from the queue head. A check is
//   dispatched, then scans the slots in ascending order (one armed-slot
//   compare per cycle while no hit waits on a stalled expiry), then flushes
//   the final hit; the first result appears at the second hit or at the flush.
//   If expiry is stalled, the scan holds at the next hit and the queue fills,
//   then cmd.ready drops; nothing is lost.
//   Reset clears all armed flags, the queue and the output register; start
//   times and durations are not cleared, as only armed slots read them.
module multi_slot_oneshot_timers (
  input  logic      clk,
  input  logic      rst,
  mst_in_if.sink    cmd,
  mst_out_if.source expiry
);
  import mst_pkg::*;

  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_head;

  mst_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  mst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .expiry  (expiry)
  );

`ifndef ASSERT_OFF
  // The back end never retires a command that is not there
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A full queue always presents a head to the back end
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> q_valid)
    else $error("command channel stalled with empty queue");

  // Reset leaves no expiry transaction pending
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !expiry.valid)
    else $error("expiry valid after reset");
`endif

endmodule
